### design/jtid_pkg.sv
// Package for the job table: widths, operation and status codes, and the
// structs passed between the control and the table cells. No dependencies.
package jtid_pkg;

    localparam int TABLE_SIZE = 16;
    localparam int PID_W      = 22;
    localparam int JOB_W      = 5;
    // stored job ids: a delete can lift the next id above the table size
    // again and again, so ids are kept in a byte and reported in JOB_W bits
    localparam int ID_W       = 8;
    localparam int STATE_W    = 2;
    localparam int CNT_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    localparam logic [STATE_W-1:0] ST_FG = 2'd1;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_DEL     = 3'd1,
        OP_SET     = 3'd2,
        OP_LKP_PID = 3'd3,
        OP_LKP_JOB = 3'd4,
        OP_FG      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NOT_FOUND = 2'd1,
        STS_FULL      = 2'd2,
        STS_BAD_KEY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [PID_W-1:0]   pid;
        logic [ID_W-1:0]    job_id;
        logic [STATE_W-1:0] state;
    } entry_t;

    // keys broadcast to every cell
    typedef struct packed {
        logic [PID_W-1:0] pid;
        logic [ID_W-1:0]  job;
    } key_t;

    // write command broadcast to every cell; only the selected cell acts
    typedef struct packed {
        logic   add;
        logic   del;
        logic   set_state;
        entry_t data;
    } cell_cmd_t;

    typedef struct packed {
        logic pid_hit;
        logic job_hit;
        logic fg_hit;
    } cell_flags_t;

endpackage

### design/jtid_cell.sv
// One slot of the job table: entry storage, key compare and one stage of
// the running-maximum chain over job ids. Depends on jtid_pkg.
module jtid_cell (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         sel,
    input  jtid_pkg::cell_cmd_t          cmd,
    input  jtid_pkg::key_t               key,
    input  logic [jtid_pkg::ID_W-1:0]    max_in,
    output jtid_pkg::entry_t             entry,
    output jtid_pkg::cell_flags_t        flags,
    output logic [jtid_pkg::ID_W-1:0]    max_out
);

    jtid_pkg::entry_t               entry_reg;
    jtid_pkg::entry_t               entry_next;
    logic [jtid_pkg::ID_W-1:0]      max_reg;
    logic [jtid_pkg::ID_W-1:0]      max_next;

    always_comb begin
        entry_next = entry_reg;
        if (sel) begin
            if (cmd.add) begin
                entry_next = cmd.data;
            end else if (cmd.del) begin
                entry_next = '0;
            end else if (cmd.set_state) begin
                entry_next.state = cmd.data.state;
            end
        end
        // pass the larger of the upstream maximum and our own job id
        max_next = (entry_reg.job_id > max_in) ? entry_reg.job_id : max_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= '0;
            max_reg   <= '0;
        end else begin
            entry_reg <= entry_next;
            max_reg   <= max_next;
        end
    end

    assign entry         = entry_reg;
    assign max_out       = max_reg;
    assign flags.pid_hit = (entry_reg.pid == key.pid);
    assign flags.job_hit = (entry_reg.job_id == key.job);
    assign flags.fg_hit  = (entry_reg.state == jtid_pkg::ST_FG);

endmodule

### design/job_table_with_id_allocation.sv
// Job table top level: command sequencer, first-hit selection, result
// register and the row of jtid_cell slots. Depends on jtid_pkg, jtid_cell.
//
// Usage
//   Input channel (s_): one command beat carries an operation, a pid, a job
//   key and a state. Output channel (m_): exactly one result beat per
//   command, with status, pid, job id and state of the entry involved.
//   Operations: add, delete, set state by pid, lookup by pid, lookup by
//   job id, first foreground entry. Failures return zero payload fields.
// Sequencing
//   A command is taken in the idle state and its result is loaded into the
//   output register in the execute state, once that register is free. A
//   delete that finds its entry then runs the job-id maximum along the row
//   of cells, one cell per cycle, in the max state and then the next-id
//   state; a new command is taken only after the last one is through.
// Reset
//   aresetn (synchronous, active low) frees every slot, zeroes all job ids
//   and states, and sets the next job id to 1. No clearing pass is needed.
// Back-pressure
//   The result register holds its beat while m_ready is low; the sequencer
//   waits with the pending command until that register is free.
module job_table_with_id_allocation (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [2:0]                      s_operation,
    input  logic [jtid_pkg::PID_W-1:0]      s_pid,
    input  logic [jtid_pkg::JOB_W-1:0]      s_job_key,
    input  logic [jtid_pkg::STATE_W-1:0]    s_new_state,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [1:0]                      m_status,
    output logic [jtid_pkg::PID_W-1:0]      m_out_pid,
    output logic [jtid_pkg::JOB_W-1:0]      m_out_job_id,
    output logic [jtid_pkg::STATE_W-1:0]    m_out_state
);

    localparam int N = jtid_pkg::TABLE_SIZE;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_MAX,
        S_NEXT
    } state_t;

    state_t                             state_reg;
    jtid_pkg::op_t                      op_reg;
    logic [jtid_pkg::PID_W-1:0]         pid_reg;
    logic [jtid_pkg::JOB_W-1:0]         key_reg;
    logic [jtid_pkg::STATE_W-1:0]       ns_reg;
    logic [jtid_pkg::ID_W-1:0]          next_id_reg;
    logic [jtid_pkg::CNT_W-1:0]         cnt_reg;
    logic                               m_valid_reg;
    jtid_pkg::status_t                  m_status_reg;
    jtid_pkg::entry_t                   m_entry_reg;

    // row of cells
    jtid_pkg::entry_t                   entries [N];
    jtid_pkg::cell_flags_t              flags   [N];
    logic [jtid_pkg::ID_W-1:0]          max_chain [N+1];
    jtid_pkg::cell_cmd_t                cmd;
    jtid_pkg::key_t                     key;
    logic [N-1:0]                       wr_sel;

    // execute-cycle decode
    logic [N-1:0]                       hits;
    logic [N-1:0]                       first_hit;
    logic                               any_hit;
    logic                               bad_key;
    logic                               out_free;
    logic                               exec_go;
    jtid_pkg::entry_t                   hit_entry;
    jtid_pkg::entry_t                   res_entry;
    jtid_pkg::status_t                  res_status;
    logic [jtid_pkg::ID_W-1:0]          id_inc;
    logic [jtid_pkg::ID_W-1:0]          id_after_add;
    logic [jtid_pkg::ID_W-1:0]          id_after_del;

    assign max_chain[0] = '0;

    // an add searches for a free slot, i.e. pid zero
    assign key.pid = (op_reg == jtid_pkg::OP_ADD) ? '0 : pid_reg;
    assign key.job = jtid_pkg::ID_W'(key_reg);

    for (genvar i = 0; i < N; i++) begin : g_cell
        jtid_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .sel     (wr_sel[i]),
            .cmd     (cmd),
            .key     (key),
            .max_in  (max_chain[i]),
            .entry   (entries[i]),
            .flags   (flags[i]),
            .max_out (max_chain[i+1])
        );
    end

    always_comb begin
        for (int i = 0; i < N; i++) begin
            case (op_reg)
                jtid_pkg::OP_ADD,
                jtid_pkg::OP_DEL,
                jtid_pkg::OP_SET,
                jtid_pkg::OP_LKP_PID: hits[i] = flags[i].pid_hit;
                jtid_pkg::OP_LKP_JOB: hits[i] = flags[i].job_hit;
                jtid_pkg::OP_FG:      hits[i] = flags[i].fg_hit;
                default:              hits[i] = 1'b0;
            endcase
        end
    end

    // isolate the lowest set bit: the first matching slot
    assign first_hit = hits & (~hits + N'(1));
    assign any_hit   = |hits;

    always_comb begin
        hit_entry = '0;
        for (int i = 0; i < N; i++) begin
            hit_entry = hit_entry | (first_hit[i] ? entries[i] : '0);
        end
    end

    always_comb begin
        bad_key = 1'b0;
        if (op_reg inside {jtid_pkg::OP_ADD, jtid_pkg::OP_DEL,
                           jtid_pkg::OP_SET, jtid_pkg::OP_LKP_PID}) begin
            bad_key = (pid_reg == '0);
        end else if (op_reg == jtid_pkg::OP_LKP_JOB) begin
            bad_key = (key_reg == '0);
        end
    end

    // next job id after an add wraps to 1 once it passes the table size;
    // both updates run modulo the stored id width
    assign id_inc       = next_id_reg + jtid_pkg::ID_W'(1);
    assign id_after_add = (id_inc > jtid_pkg::ID_W'(N)) ? jtid_pkg::ID_W'(1) : id_inc;
    assign id_after_del = max_chain[N] + jtid_pkg::ID_W'(1);

    assign out_free = !m_valid_reg || m_ready;
    assign exec_go  = (state_reg == S_EXEC) && out_free;

    always_comb begin
        res_entry  = '0;
        res_status = jtid_pkg::STS_NOT_FOUND;
        if (bad_key) begin
            res_status = jtid_pkg::STS_BAD_KEY;
        end else if (!any_hit) begin
            res_status = (op_reg == jtid_pkg::OP_ADD) ? jtid_pkg::STS_FULL
                                                      : jtid_pkg::STS_NOT_FOUND;
        end else begin
            res_status = jtid_pkg::STS_OK;
            res_entry  = hit_entry;
            case (op_reg)
                jtid_pkg::OP_ADD: begin
                    res_entry.pid    = pid_reg;
                    res_entry.job_id = next_id_reg;
                    res_entry.state  = ns_reg;
                end
                jtid_pkg::OP_SET: begin
                    res_entry.state = ns_reg;
                end
                default: begin
                    res_entry = hit_entry;
                end
            endcase
        end
    end

    // write the first matching cell, only when the command succeeds
    always_comb begin
        cmd.add         = (op_reg == jtid_pkg::OP_ADD);
        cmd.del         = (op_reg == jtid_pkg::OP_DEL);
        cmd.set_state   = (op_reg == jtid_pkg::OP_SET);
        cmd.data.pid    = pid_reg;
        cmd.data.job_id = next_id_reg;
        cmd.data.state  = ns_reg;
        wr_sel          = (exec_go && !bad_key) ? first_hit : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            next_id_reg <= jtid_pkg::ID_W'(1);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the beat once taken, unless a new one loads on this edge
            if (m_valid_reg && m_ready && !exec_go) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        op_reg    <= jtid_pkg::op_t'(s_operation);
                        pid_reg   <= s_pid;
                        key_reg   <= s_job_key;
                        ns_reg    <= s_new_state;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    // hold the command until the result register is free
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= res_status;
                        m_entry_reg  <= res_entry;
                        cnt_reg      <= '0;
                        if (!bad_key && any_hit && op_reg == jtid_pkg::OP_DEL) begin
                            state_reg <= S_MAX;
                        end else begin
                            state_reg <= S_IDLE;
                        end
                        if (!bad_key && any_hit && op_reg == jtid_pkg::OP_ADD) begin
                            next_id_reg <= id_after_add;
                        end
                    end
                end
                S_MAX: begin
                    // advance until the maximum has rippled to the last cell
                    cnt_reg <= cnt_reg + jtid_pkg::CNT_W'(1);
                    if (cnt_reg == jtid_pkg::CNT_W'(N - 1)) begin
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    next_id_reg <= id_after_del;
                    state_reg   <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_out_pid    = m_entry_reg.pid;
    assign m_out_job_id = m_entry_reg.job_id[jtid_pkg::JOB_W-1:0];
    assign m_out_state  = m_entry_reg.state;

`ifndef SYNTHESIS
    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(wr_sel))
        else $error("more than one table cell written in a cycle");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_out_pid)
                                   && $stable(m_out_job_id) && $stable(m_out_state)))
        else $error("result beat changed while stalled");

    a_write_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_sel != '0) |-> out_free)
        else $error("table written while result register is occupied");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second command taken while one is in progress");
`endif

endmodule
